/* rtl/core/stream_substring_search_defines.svh */
// assertion macros used by the checker file
`ifndef STREAM_SUBSTRING_SEARCH_DEFINES_SVH
`define STREAM_SUBSTRING_SEARCH_DEFINES_SVH

// same-cycle implication, held off during reset
`define SSS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stream_substring_search: assertion failed");

// next-cycle implication, held off during reset
`define SSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stream_substring_search: assertion failed");

`endif

/* rtl/core/sss_pkg.sv */
// shared constants and register codes for the substring search block
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

  // largest needle and width of the offset counter
  localparam int MAX_NEEDLE  = 8;
  localparam int OFFSET_BITS = 16;

  // fixed field widths
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 4;
  localparam int NEEDLE_W    = 64;
  localparam int OFF_FIELD_W = 16;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 64;

  // derived widths
  localparam int IDX_W  = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
  localparam int SEEN_W = OFFSET_BITS + 1;

  // saturation point of the byte counter
  localparam logic [SEEN_W-1:0] SEEN_CAP =
    SEEN_W'((64'(1) << OFFSET_BITS) + 64'(MAX_NEEDLE));

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_BYTES = CFG_IDX_W'(1);

endpackage

`default_nettype wire

/* rtl/core/sss_intf.sv */
// stream and configuration channel interfaces
`timescale 1ns / 1ps
`default_nettype none

// haystack byte channel
interface sss_in_if;
  logic                        valid;
  logic                        ready;
  logic [sss_pkg::BYTE_W-1:0]  hay_byte;
  logic                        hay_last;
  modport source (output valid, output hay_byte, output hay_last, input ready);
  modport sink   (input valid, input hay_byte, input hay_last, output ready);
endinterface

// search result channel
interface sss_out_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [sss_pkg::OFF_FIELD_W-1:0]  match_offset;
  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

// register write channel
interface sss_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sss_pkg::CFG_IDX_W-1:0]   index;
  logic [sss_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/stream_substring_search.sv */
// top level: first-match substring search over a byte stream
//
//   channel  dir  words                         handshake
//   hay      in   hay_byte, hay_last            valid / ready
//   res      out  found, match_offset           valid / ready
//   cfg      in   index, data                   valid / ready (always ready)
//
// one haystack word per cycle; the cell chain compares all needle bytes at once
// a result word appears in the output register the cycle after the last word
// hay stalls only while a result is held and res is not ready
// rst is synchronous: needle length and bytes, window, counter and hit clear
`timescale 1ns / 1ps
`default_nettype none

module stream_substring_search (
  input  wire logic  clk,
  input  wire logic  rst,
  sss_in_if.sink     hay,
  sss_out_if.source  res,
  sss_cfg_if.sink    cfg
);

  localparam int MAX_NEEDLE  = sss_pkg::MAX_NEEDLE;
  localparam int OFFSET_BITS = sss_pkg::OFFSET_BITS;
  localparam int BYTE_W      = sss_pkg::BYTE_W;
  localparam int LEN_W       = sss_pkg::LEN_W;
  localparam int IDX_W       = sss_pkg::IDX_W;
  localparam int SEEN_W      = sss_pkg::SEEN_W;
  localparam int OFF_FIELD_W = sss_pkg::OFF_FIELD_W;

  // configuration registers
  logic [LEN_W-1:0]             pattern_len;
  logic [sss_pkg::NEEDLE_W-1:0] needle_bytes;

  // haystack state
  logic [SEEN_W-1:0]      bytes_seen;
  logic                   hit_seen;
  logic [OFFSET_BITS-1:0] hit_offset;

  // output register
  logic                   res_valid;
  logic                   res_found;
  logic [OFF_FIELD_W-1:0] res_offset;

  logic                   accept;
  logic [LEN_W-1:0]       len_c;
  logic [BYTE_W-1:0]      tap [MAX_NEEDLE];
  logic [MAX_NEEDLE-1:0]  cell_hit;
  logic [SEEN_W-1:0]      seen_inc;
  logic [SEEN_W-1:0]      start;
  logic                   match;

  assign cfg.ready = 1'b1;
  assign hay.ready = !res_valid || res.ready;
  assign accept    = hay.valid && hay.ready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len  <= '0;
      needle_bytes <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == sss_pkg::REG_PATTERN_LEN) begin
        pattern_len <= cfg.data[LEN_W-1:0];
      end else if (cfg.index == sss_pkg::REG_NEEDLE_BYTES) begin
        needle_bytes <= cfg.data;
      end
    end
  end

  // clamp an oversized length
  assign len_c = (pattern_len > LEN_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE) : pattern_len;

  // cell chain: cell d sees the word accepted d words back
  assign tap[0] = hay.hay_byte;

  for (genvar d = 0; d < MAX_NEEDLE; d++) begin : g_cell
    logic [LEN_W-1:0]  sel_full;
    logic              active;
    logic [BYTE_W-1:0] ref_byte;

    assign active   = LEN_W'(d) < len_c;
    assign sel_full = len_c - LEN_W'(1) - LEN_W'(d);
    assign ref_byte = needle_bytes[BYTE_W * sel_full[IDX_W-1:0] +: BYTE_W];

    if (d < MAX_NEEDLE - 1) begin : g_link
      sss_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (accept),
        .clear    (hay.hay_last),
        .active   (active),
        .byte_in  (tap[d]),
        .ref_byte (ref_byte),
        .byte_out (tap[d+1]),
        .hit      (cell_hit[d])
      );
    end else begin : g_end
      sss_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (accept),
        .clear    (hay.hay_last),
        .active   (active),
        .byte_in  (tap[d]),
        .ref_byte (ref_byte),
        .byte_out (),
        .hit      (cell_hit[d])
      );
    end
  end

  // start of the candidate match and its qualification
  assign seen_inc = bytes_seen + SEEN_W'(1);
  assign start    = seen_inc - SEEN_W'(len_c);
  assign match    = !hit_seen && (len_c != '0) && (bytes_seen < sss_pkg::SEEN_CAP)
                    && (seen_inc >= SEEN_W'(len_c)) && !start[SEEN_W-1] && (&cell_hit);

  // byte counter and first-hit record
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      hit_seen   <= 1'b0;
      hit_offset <= '0;
    end else if (accept) begin
      if (hay.hay_last) begin
        bytes_seen <= '0;
        hit_seen   <= 1'b0;
        hit_offset <= '0;
      end else begin
        if (bytes_seen < sss_pkg::SEEN_CAP) begin
          bytes_seen <= seen_inc;
        end
        if (match) begin
          hit_seen   <= 1'b1;
          hit_offset <= start[OFFSET_BITS-1:0];
        end
      end
    end
  end

  // result word on the last haystack word
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && hay.hay_last) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hay.hay_last) begin
      priority if (len_c == '0) begin
        res_found  <= 1'b1;
        res_offset <= '0;
      end else if (hit_seen) begin
        res_found  <= 1'b1;
        res_offset <= OFF_FIELD_W'(hit_offset);
      end else if (match) begin
        res_found  <= 1'b1;
        res_offset <= OFF_FIELD_W'(start[OFFSET_BITS-1:0]);
      end else begin
        res_found  <= 1'b0;
        res_offset <= '0;
      end
    end
  end

  assign res.valid        = res_valid;
  assign res.found        = res_found;
  assign res.match_offset = res_offset;

endmodule

`default_nettype wire

/* rtl/core/sss_cell.sv */
// one window cell: compares the byte passing through and holds it for the next cell
`timescale 1ns / 1ps
`default_nettype none

module sss_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        shift,
  input  wire logic                        clear,
  input  wire logic                        active,
  input  wire logic [sss_pkg::BYTE_W-1:0]  byte_in,
  input  wire logic [sss_pkg::BYTE_W-1:0]  ref_byte,
  output logic      [sss_pkg::BYTE_W-1:0]  byte_out,
  output logic                             hit
);

  // an idle cell never blocks a match
  assign hit = !active || (byte_in == ref_byte);

  // window byte, emptied at the end of each haystack
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_out <= '0;
    end else if (shift) begin
      if (clear) begin
        byte_out <= '0;
      end else begin
        byte_out <= byte_in;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sss_checker.sv */
// port-level checks for the substring search block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "stream_substring_search_defines.svh"

module sss_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              hay_valid,
  input wire logic                              hay_ready,
  input wire logic                              hay_last,
  input wire logic                              res_valid,
  input wire logic                              res_ready,
  input wire logic                              res_found,
  input wire logic [sss_pkg::OFF_FIELD_W-1:0]   res_offset
);

  // a held result word does not change
  `SSS_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_found) && $stable(res_offset))

  // a new result follows only an accepted last word
  `SSS_ASSERT_NOW(a_res_cause, clk, rst, $rose(res_valid), $past(hay_valid && hay_ready && hay_last))

  // not found always carries a zero offset
  `SSS_ASSERT_NOW(a_miss_zero, clk, rst, res_valid && !res_found, res_offset == '0)

  // input never stalls while the output register is empty
  `SSS_ASSERT_NOW(a_no_idle_stall, clk, rst, !res_valid, hay_ready)

endmodule

bind stream_substring_search sss_checker u_sss_checker (
  .clk        (clk),
  .rst        (rst),
  .hay_valid  (hay.valid),
  .hay_ready  (hay.ready),
  .hay_last   (hay.hay_last),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_found  (res.found),
  .res_offset (res.match_offset)
);

`default_nettype wire

/* tb/sv/tb.sv */
// testbench for stream_substring_search: directed table, random haystacks, scoreboard
`timescale 1ns / 1ps

module tb;
  import sss_pkg::*;

  // index not mapped to any register, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'hF;

  localparam int RESET_CYCLES    = 10;
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int HAY_BUF_DEPTH   = 32;
  localparam int DIR_ROWS        = 21;

  localparam int unsigned SCAN_CAP  = (32'd1 << OFFSET_BITS) + MAX_NEEDLE;
  localparam int unsigned OFF_LIMIT = (32'd1 << OFFSET_BITS) - 1;

  // needle lengths of the first random phases: full, empty, oversized, single
  localparam logic [LEN_W-1:0] LEN_PLAN [4] = '{4'd8, 4'd0, 4'd15, 4'd1};
  // per-phase idle percentages, sender and receiver
  localparam int SEND_IDLE_PLAN [4] = '{0, 52, 0, 21};
  localparam int RECV_STALL_PLAN [4] = '{0, 0, 52, 21};

  typedef enum logic {ROW_CFG, ROW_BYTES} row_kind_e;

  typedef struct packed {
    logic                   found;
    logic [OFF_FIELD_W-1:0] offset;
  } search_res_t;

  // one directed step: a register write, or a run of identical haystack words
  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_data;
    logic [BYTE_W-1:0]      hay_byte;
    logic [16:0]            count;
    logic                   last;
    logic                   typed;
    logic                   found;
    logic [OFF_FIELD_W-1:0] offset;
  } dir_row_t;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // empty needle straight after reset
    '{ROW_BYTES, REG_SPARE, 64'h0, 8'h00, 17'd1, 1'b1, 1'b1, 1'b1, 16'h0000},
    // oversized length clamps to a full eight-byte needle
    '{ROW_CFG, REG_NEEDLE_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 17'd0, 0, 0, 0, 16'h0},
    '{ROW_CFG, REG_PATTERN_LEN, 64'h0000_0000_0000_000F, 8'h00, 17'd0, 0, 0, 0, 16'h0},
    '{ROW_BYTES, REG_SPARE, 64'h0, 8'hFF, 17'd8, 1'b1, 1'b1, 1'b1, 16'h0000},
    // haystack one short of the needle
    '{ROW_BYTES, REG_SPARE, 64'h0, 8'hFF, 17'd7, 1'b1, 1'b1, 1'b0, 16'h0000},
    '{ROW_BYTES, REG_SPARE, 64'h0, 8'h00, 17'd1, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{ROW_BYTES, REG_SPARE, 64'h0, 8'hFF, 17'd8, 1'b1, 1'b1, 1'b1, 16'h0001},
    // upper data bits of the length write are dropped, length zero
    '{ROW_CFG, REG_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFF0, 8'h00, 17'd0, 0, 0, 0, 16'h0},
    '{ROW_BYTES, REG_SPARE, 64'h0, 8'h5A, 17'd3, 1'b1, 1'b1, 1'b1, 16'h0000},
    // zero needle against a zero window that is still too short
    '{ROW_CFG, REG_NEEDLE_BYTES, 64'h0000_0000_0000_0000, 8'h00, 17'd0, 0, 0, 0, 16'h0},
    '{ROW_CFG, REG_PATTERN_LEN, 64'h0000_0000_0000_0003, 8'h00, 17'd0, 0, 0, 0, 16'h0},
    '{ROW_BYTES, REG_SPARE, 64'h0, 8'h00, 17'd2, 1'b1, 1'b1, 1'b0, 16'h0000},
    '{ROW_CFG, REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 17'd0, 0, 0, 0, 16'h0},
    '{ROW_BYTES, REG_SPARE, 64'h0, 8'h00, 17'd3, 1'b1, 1'b1, 1'b1, 16'h0000},
    // length changed in the middle of a haystack, first hit kept
    '{ROW_CFG, REG_NEEDLE_BYTES, 64'h0000_0000_0000_3C5A, 8'h00, 17'd0, 0, 0, 0, 16'h0},
    '{ROW_CFG, REG_PATTERN_LEN, 64'h0000_0000_0000_0002, 8'h00, 17'd0, 0, 0, 0, 16'h0},
    '{ROW_BYTES, REG_SPARE, 64'h0, 8'h5A, 17'd1, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{ROW_CFG, REG_PATTERN_LEN, 64'h0000_0000_0000_0001, 8'h00, 17'd0, 0, 0, 0, 16'h0},
    '{ROW_BYTES, REG_SPARE, 64'h0, 8'h5A, 17'd1, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{ROW_CFG, REG_PATTERN_LEN, 64'h0000_0000_0000_0002, 8'h00, 17'd0, 0, 0, 0, 16'h0},
    '{ROW_BYTES, REG_SPARE, 64'h0, 8'h3C, 17'd1, 1'b1, 1'b0, 1'b0, 16'h0000}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  sss_in_if  hay_bus ();
  sss_out_if res_bus ();
  sss_cfg_if cfg_bus ();

  stream_substring_search DUT (
    .clk (clk),
    .rst (rst),
    .hay (hay_bus),
    .res (res_bus),
    .cfg (cfg_bus)
  );

  // 12 ns period
  always #6 clk = ~clk;

  // shadow registers and scan state of the search
  logic [LEN_W-1:0]      shadow_len    = '0;
  logic [NEEDLE_W-1:0]   shadow_needle = '0;
  logic [NEEDLE_W-1:0]   scan_window   = '0;
  int unsigned           scan_count    = 0;
  logic                  scan_hit      = 1'b0;
  int unsigned           scan_hit_at   = 0;

  search_res_t due_results [$];
  search_res_t head;
  int          mismatches     = 0;
  int          quiet_cycles   = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_asks      = 0;
  int          hold_seen      = 0;
  int          hold_left      = 0;

  // advance the search by one haystack word, give the result on the last one
  function automatic void search_byte(input logic [BYTE_W-1:0] b, input logic fin,
                                      output logic gives, output search_res_t r);
    int unsigned         eff_len;
    int unsigned         start;
    logic [NEEDLE_W-1:0] tail;
    logic [NEEDLE_W-1:0] mask;
    eff_len = (shadow_len > MAX_NEEDLE) ? MAX_NEEDLE : shadow_len;
    scan_window = (scan_window >> BYTE_W) | (64'(b) << (BYTE_W * (MAX_NEEDLE - 1)));
    if (!scan_hit && eff_len != 0 && scan_count < SCAN_CAP && scan_count + 1 >= eff_len) begin
      start = scan_count + 1 - eff_len;
      tail  = scan_window >> (BYTE_W * (MAX_NEEDLE - eff_len));
      mask  = (eff_len >= MAX_NEEDLE) ? '1 : ((64'd1 << (BYTE_W * eff_len)) - 64'd1);
      if (start <= OFF_LIMIT && tail == (shadow_needle & mask)) begin
        scan_hit    = 1'b1;
        scan_hit_at = start;
      end
    end
    if (scan_count < SCAN_CAP) scan_count++;
    gives = fin;
    r     = '0;
    if (fin) begin
      if (eff_len == 0) begin
        r.found = 1'b1;
      end else if (scan_hit) begin
        r.found  = 1'b1;
        r.offset = OFF_FIELD_W'(scan_hit_at);
      end
      scan_window = '0;
      scan_count  = 0;
      scan_hit    = 1'b0;
      scan_hit_at = 0;
    end
  endfunction

  // offer one word, possibly after idle cycles; valid is left high on return
  task automatic send_word(input logic [BYTE_W-1:0] b, input logic fin,
                           input logic use_typed, input search_res_t typed);
    logic        gives;
    search_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      hay_bus.valid <= 1'b0;
      @(posedge clk);
    end
    hay_bus.valid    <= 1'b1;
    hay_bus.hay_byte <= b;
    hay_bus.hay_last <= fin;
    do @(posedge clk); while (!hay_bus.ready);
    search_byte(b, fin, gives, r);
    if (gives) due_results.push_back(use_typed ? typed : r);
  endtask

  // register write; valid is left high on return
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == REG_PATTERN_LEN) shadow_len = data[LEN_W-1:0];
    else if (idx == REG_NEEDLE_BYTES) shadow_needle = data;
  endtask

  // stop offering words and wait until the block has drained
  task automatic quiesce();
    hay_bus.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        res_bus.ready <= 1'b0;
        hold_left--;
      end else if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result checking against the oldest due word
  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (due_results.size() == 0) begin
        $error("result word with none due: found %0b match_offset %0d",
               res_bus.found, res_bus.match_offset);
        mismatches++;
      end else begin
        head = due_results.pop_front();
        if (res_bus.found !== head.found) begin
          $error("found: expected %0b, actual %0b", head.found, res_bus.found);
          mismatches++;
        end
        if (res_bus.match_offset !== head.offset) begin
          $error("match_offset: expected %0d, actual %0d", head.offset, res_bus.match_offset);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (hay_bus.valid && hay_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    dir_row_t            row;
    search_res_t         typed_res;
    logic                cfg_open;
    logic [BYTE_W-1:0]   hay_buf [HAY_BUF_DEPTH];
    logic [NEEDLE_W-1:0] needle_pick;
    logic [CFG_DATA_W-1:0] len_data;
    int                  p;
    int                  k;
    int                  items;
    int                  hay_len;
    int                  pos;
    int                  plant;
    int                  flip_at;

    hay_bus.valid    = 1'b0;
    hay_bus.hay_byte = '0;
    hay_bus.hay_last = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = '0;
    cfg_bus.data     = '0;
    cfg_open         = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        if (!cfg_open) quiesce();
        write_reg(row.reg_idx, row.reg_data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_bus.valid <= 1'b0;
        cfg_open        = 1'b0;
        typed_res.found  = row.found;
        typed_res.offset = row.offset;
        for (k = 0; k < row.count; k++)
          send_word(row.hay_byte, row.last && (k == row.count - 1), row.typed, typed_res);
      end
    end

    // random phases, each with its own needle and idle profile
    for (p = 0; p < PHASES; p++) begin
      quiesce();
      case (p % 3)
        0: needle_pick = {$urandom, $urandom};
        1: for (k = 0; k < MAX_NEEDLE; k++)
             needle_pick[BYTE_W*k +: BYTE_W] = $urandom_range(1) ? 8'hA5 : 8'h5A;
        default: needle_pick = (p < 4) ? '1 : '0;
      endcase
      len_data = {$urandom, $urandom};
      len_data[LEN_W-1:0] = (p < 4) ? LEN_PLAN[p] : LEN_W'($urandom_range(15));
      write_reg(REG_NEEDLE_BYTES, needle_pick);
      write_reg(REG_PATTERN_LEN, len_data);
      if (p % 2 == 0) write_reg(REG_SPARE, {$urandom, $urandom});
      cfg_bus.valid <= 1'b0;

      send_idle_pct  = SEND_IDLE_PLAN[p % 4];
      recv_stall_pct = RECV_STALL_PLAN[p % 4];
      // long receiver hold-off while words keep coming
      if (p % 4 == 0) hold_asks++;

      items = 0;
      while (items < ITEMS_PER_PHASE) begin
        hay_len = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 10);
        for (k = 0; k < hay_len; k++)
          hay_buf[k] = ($urandom_range(3) == 0) ? BYTE_W'($urandom_range(255))
                                                : shadow_needle[BYTE_W*$urandom_range(7) +: BYTE_W];
        // plant the needle, sometimes with one bit flipped or cut off at the end
        plant = $urandom_range(9);
        if (plant < 8) begin
          pos     = $urandom_range(hay_len - 1);
          flip_at = (plant >= 6) ? $urandom_range(MAX_NEEDLE - 1) : MAX_NEEDLE;
          for (k = 0; k < MAX_NEEDLE && pos + k < hay_len; k++)
            hay_buf[pos+k] = shadow_needle[BYTE_W*k +: BYTE_W] ^
                             ((k == flip_at) ? (8'd1 << $urandom_range(7)) : 8'd0);
        end
        for (k = 0; k < hay_len; k++)
          send_word(hay_buf[k], k == hay_len - 1, 1'b0, '0);
        items += hay_len;
      end

      // leave a haystack open so the next setting lands mid-stream
      if ($urandom_range(1)) begin
        hay_len = $urandom_range(1, 3);
        for (k = 0; k < hay_len; k++)
          send_word(BYTE_W'($urandom_range(255)), 1'b0, 1'b0, '0);
      end
    end

    quiesce();
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
